@@ rtl/psus_pkg.sv @@
// shared types and constants for the particle swarm update step unit
package psus_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned LimW  = 31;
  localparam int unsigned FitW  = 36;
  localparam int unsigned SqW   = 31;

  localparam int unsigned InDataW  = 256;
  localparam int unsigned OutDataW = 152;

  localparam logic [FitW-1:0] FitMax = {FitW{1'b1}};

  // one input word as unpacked from the stream
  typedef struct packed {
    logic                     start_of_run;
    logic [IdxW-1:0]          particle_index;
    logic signed [CoordW-1:0] position;
    logic signed [CoordW-1:0] velocity;
    logic signed [CoordW-1:0] personal_best_pos;
    logic signed [CoordW-1:0] global_best_pos;
    logic [FracW-1:0]         rand_one;
    logic [FracW-1:0]         rand_two;
    logic [FracW-1:0]         inertia;
    logic [LimW-1:0]          velocity_limit;
    logic [FitW-1:0]          personal_best_fitness;
    logic                     last_dimension;
  } psus_in_t;

  // fields that ride along the front pipeline untouched
  typedef struct packed {
    logic            start_of_run;
    logic [IdxW-1:0] particle_index;
    logic [FitW-1:0] personal_best_fitness;
    logic            last_dimension;
  } psus_meta_t;

  // queue entry from front to back
  typedef struct packed {
    psus_meta_t               meta;
    logic signed [CoordW-1:0] new_position;
    logic signed [CoordW-1:0] new_velocity;
    logic [SqW-1:0]           square;
  } psus_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psus_fifo_stat_t;

  // one result word
  typedef struct packed {
    logic signed [CoordW-1:0] new_position;
    logic signed [CoordW-1:0] new_velocity;
    logic                     is_last;
    logic [FitW-1:0]          fitness;
    logic                     personal_improved;
    logic                     global_improved;
    logic [IdxW-1:0]          best_particle;
    logic [FitW-1:0]          best_value;
  } psus_res_t;

endpackage

@@ rtl/psus_front.sv @@
// front pipeline: velocity and position update and square of the integer part
module psus_front
  import psus_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  psus_in_t    item_i,
  output logic        valid_o,
  output psus_entry_t entry_o
);

  logic [5:0] vld_q;

  // stage 1: differences
  psus_meta_t               m1_q;
  logic signed [CoordW-1:0] x1_q, v1_q;
  logic signed [CoordW:0]   d1_q, d2_q;
  logic [FracW-1:0]         r1_q, r2_q, w1_q;
  logic [LimW-1:0]          lim1_q;

  // stage 2: products
  psus_meta_t               m2_q;
  logic signed [CoordW-1:0] x2_q;
  logic [LimW-1:0]          lim2_q;
  logic signed [48:0]       p0_q;
  logic signed [49:0]       p1_q, p2_q;
  logic signed [48:0]       p0_d;
  logic signed [49:0]       p1_d, p2_d;

  // stage 3: floored sum
  psus_meta_t               m3_q;
  logic signed [CoordW-1:0] x3_q;
  logic [LimW-1:0]          lim3_q;
  logic signed [35:0]       sum_q, sum_d;

  // stage 4: clamp
  psus_meta_t               m4_q;
  logic signed [CoordW-1:0] x4_q;
  logic signed [CoordW-1:0] nv4_q, nv4_d;
  logic signed [35:0]       lim_pos, lim_neg;

  // stage 5: saturating position
  psus_meta_t               m5_q;
  logic signed [CoordW-1:0] nv5_q, nx5_q, nx5_d;
  logic signed [CoordW:0]   nx_wide;

  // stage 6: integer part squared
  psus_meta_t               m6_q;
  logic signed [CoordW-1:0] nv6_q, nx6_q;
  logic [SqW-1:0]           sq6_q, sq6_d;
  logic signed [CoordW-1:0] nx_bias;
  logic signed [15:0]       ipart;
  logic signed [31:0]       sq_full;

  psus_meta_t meta_in;

  assign meta_in.start_of_run          = item_i.start_of_run;
  assign meta_in.particle_index        = item_i.particle_index;
  assign meta_in.personal_best_fitness = item_i.personal_best_fitness;
  assign meta_in.last_dimension        = item_i.last_dimension;

  assign p0_d = $signed({1'b0, w1_q}) * v1_q;
  assign p1_d = $signed({1'b0, r1_q}) * d1_q;
  assign p2_d = $signed({1'b0, r2_q}) * d2_q;

  // floor(p/2^16) is an arithmetic shift; the factor 2 drops one bit of shift
  assign sum_d = {{3{p0_q[48]}}, p0_q[48:16]}
               + {p1_q[49], p1_q[49:15]}
               + {p2_q[49], p2_q[49:15]};

  assign lim_pos = $signed({5'b0, lim3_q});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (sum_q > lim_pos) begin
      nv4_d = lim_pos[CoordW-1:0];
    end else if (sum_q < lim_neg) begin
      nv4_d = lim_neg[CoordW-1:0];
    end else begin
      nv4_d = sum_q[CoordW-1:0];
    end
  end

  assign nx_wide = {x4_q[CoordW-1], x4_q} + {nv4_q[CoordW-1], nv4_q};

  always_comb begin
    if (nx_wide[CoordW] != nx_wide[CoordW-1]) begin
      nx5_d = nx_wide[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      nx5_d = nx_wide[CoordW-1:0];
    end
  end

  // truncation toward zero: bias negative values before the shift
  assign nx_bias = nx5_q[CoordW-1] ? (nx5_q + 32'sh0000_ffff) : nx5_q;
  assign ipart   = nx_bias[31:16];
  assign sq_full = ipart * ipart;
  assign sq6_d   = sq_full[SqW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= meta_in;
      x1_q   <= item_i.position;
      v1_q   <= item_i.velocity;
      d1_q   <= {item_i.personal_best_pos[CoordW-1], item_i.personal_best_pos}
              - {item_i.position[CoordW-1], item_i.position};
      d2_q   <= {item_i.global_best_pos[CoordW-1], item_i.global_best_pos}
              - {item_i.position[CoordW-1], item_i.position};
      r1_q   <= item_i.rand_one;
      r2_q   <= item_i.rand_two;
      w1_q   <= item_i.inertia;
      lim1_q <= item_i.velocity_limit;

      m2_q   <= m1_q;
      x2_q   <= x1_q;
      lim2_q <= lim1_q;
      p0_q   <= p0_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;

      m3_q   <= m2_q;
      x3_q   <= x2_q;
      lim3_q <= lim2_q;
      sum_q  <= sum_d;

      m4_q   <= m3_q;
      x4_q   <= x3_q;
      nv4_q  <= nv4_d;

      m5_q   <= m4_q;
      nv5_q  <= nv4_q;
      nx5_q  <= nx5_d;

      m6_q   <= m5_q;
      nv6_q  <= nv5_q;
      nx6_q  <= nx5_q;
      sq6_q  <= sq6_d;
    end
  end

  assign valid_o              = vld_q[5];
  assign entry_o.meta         = m6_q;
  assign entry_o.new_position = nx6_q;
  assign entry_o.new_velocity = nv6_q;
  assign entry_o.square       = sq6_q;

endmodule

@@ rtl/psus_fifo.sv @@
// short queue between the front pipeline and the back stage
module psus_fifo
  import psus_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psus_entry_t     entry_i,
  input  logic            pop_i,
  output psus_entry_t     head_o,
  output psus_fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  psus_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/psus_back.sv @@
// back stage: fitness accumulation, best tracking and result register
module psus_back
  import psus_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  psus_entry_t entry_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output psus_res_t   res_o
);

  logic [FitW-1:0] sum_q, sum_d;
  logic [FitW-1:0] gbv_q, gbv_d;
  logic [IdxW-1:0] gbi_q, gbi_d;
  logic            valid_q;
  psus_res_t       res_q, res_d;

  logic [FitW:0]   fit_wide;
  logic [FitW-1:0] fit;
  logic [FitW-1:0] gbv_cur;
  logic [IdxW-1:0] gbi_cur;
  logic            pimp, gimp, last;

  assign pop_o = avail_i && (!valid_q || ready_i);
  assign last  = entry_i.meta.last_dimension;

  assign fit_wide = {1'b0, sum_q} + {{(FitW + 1 - SqW){1'b0}}, entry_i.square};
  assign fit      = fit_wide[FitW] ? FitMax : fit_wide[FitW-1:0];

  always_comb begin
    gbv_cur = entry_i.meta.start_of_run ? FitMax : gbv_q;
    gbi_cur = entry_i.meta.start_of_run ? '0 : gbi_q;
    pimp    = last && (fit < entry_i.meta.personal_best_fitness);
    gimp    = pimp && (fit < gbv_cur);
    gbv_d   = gimp ? fit : gbv_cur;
    gbi_d   = gimp ? entry_i.meta.particle_index : gbi_cur;
    sum_d   = last ? '0 : fit;

    res_d.new_position      = entry_i.new_position;
    res_d.new_velocity      = entry_i.new_velocity;
    res_d.is_last           = last;
    res_d.fitness           = last ? fit : '0;
    res_d.personal_improved = pimp;
    res_d.global_improved   = gimp;
    res_d.best_particle     = gbi_d;
    res_d.best_value        = gbv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      gbv_q   <= FitMax;
      gbi_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        sum_q   <= sum_d;
        gbv_q   <= gbv_d;
        gbi_q   <= gbi_d;
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ rtl/particle_swarm_update_step_unit.sv @@
// top level of the particle swarm update step unit
// one word on the slave stream is one dimension of one particle; tuser carries
// the start-of-run flag that resets the global best, tlast marks the final
// dimension of the particle. one result word leaves the master stream for each
// input word, in order; its tlast copies the input tlast, and on such words
// the fitness, improvement flags and updated global best are meaningful.
// from input accept to result valid a word passes six front pipeline stages
// (difference, three parallel multipliers, floored sum, clamp, saturating add,
// truncate and square), the first loaded at the accept edge, then one queue
// slot and one back register.
// throughput is one word per cycle while the receiver accepts; the back stage's
// single 36-bit add and its two compares form the accumulation loop.
// when the receiver stalls the result register holds, the queue fills and the
// front pipeline freezes as a whole once the queue is full; s_axis_tready_o
// then drops until a slot frees up.
// reset clears the pipeline valids, the queue, the fitness sum to zero, and
// sets the global best value to all ones with index zero.
module particle_swarm_update_step_unit
  import psus_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata from bit 0: particle_index(10) position(32) velocity(32)
  // personal_best_pos(32) global_best_pos(32) rand_one(16) rand_two(16)
  // inertia(16) velocity_limit(31) personal_best_fitness(36) zero pad(3)
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: start_of_run(1)
  input  logic                s_axis_tuser_i,
  input  logic                s_axis_tlast_i,
  // master stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata from bit 0: new_position(32) new_velocity(32) fitness(36)
  // personal_improved(1) global_improved(1) best_particle(10)
  // best_value(36) zero pad(4)
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  psus_in_t        item;
  psus_entry_t     front_entry, head;
  psus_fifo_stat_t fifo_stat;
  psus_res_t       res;
  logic            front_en, front_valid, pop;

  // unpack the input word
  assign item.start_of_run          = s_axis_tuser_i;
  assign item.particle_index        = s_axis_tdata_i[9:0];
  assign item.position              = s_axis_tdata_i[41:10];
  assign item.velocity              = s_axis_tdata_i[73:42];
  assign item.personal_best_pos     = s_axis_tdata_i[105:74];
  assign item.global_best_pos       = s_axis_tdata_i[137:106];
  assign item.rand_one              = s_axis_tdata_i[153:138];
  assign item.rand_two              = s_axis_tdata_i[169:154];
  assign item.inertia               = s_axis_tdata_i[185:170];
  assign item.velocity_limit        = s_axis_tdata_i[216:186];
  assign item.personal_best_fitness = s_axis_tdata_i[252:217];
  assign item.last_dimension        = s_axis_tlast_i;

  // front runs whenever the queue has room for what leaves stage six
  assign front_en        = !fifo_stat.full;
  assign s_axis_tready_o = front_en;

  psus_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (front_en),
    .valid_i (s_axis_tvalid_i),
    .item_i  (item),
    .valid_o (front_valid),
    .entry_o (front_entry)
  );

  psus_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid && front_en),
    .entry_i (front_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (fifo_stat)
  );

  psus_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!fifo_stat.empty),
    .entry_i (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  // pack the result word
  assign m_axis_tdata_o = {4'b0, res.best_value, res.best_particle, res.global_improved,
                           res.personal_improved, res.fitness, res.new_velocity,
                           res.new_position};
  assign m_axis_tlast_o = res.is_last;

  // the front never hands the queue a word it cannot store
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_valid |-> !fifo_stat.full || !front_en)
    else $error("queue overflow");

  // a global improvement records this fitness as the best value
  a_best_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.global_improved) |->
      (res.personal_improved && res.best_value == res.fitness))
    else $error("global best not updated");

  // words that are not last carry no fitness or flags
  a_not_last_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |->
      (res.fitness == '0 && !res.personal_improved && !res.global_improved))
    else $error("fitness fields set on a non-last word");

  // the back never pops an empty queue
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("queue underflow");

endmodule
